FILE: rtl/mdio_management_master_assert.svh
// Assertion macros for the MDIO management master
`ifndef MDIO_MANAGEMENT_MASTER_ASSERT_SVH
`define MDIO_MANAGEMENT_MASTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MDIOMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MDIOMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mdiomm_pkg.sv
// Shared types and constants for the MDIO management master
package mdiomm_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    localparam logic CFG_PHY_ADDRESS = 1'b0;
    localparam logic CFG_HALF_PERIOD = 1'b1;

    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned HALF_W     = 10;
    localparam int unsigned BIT_W      = 6;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = HALF_W'(50);

    localparam logic [1:0] START_BITS = 2'b01;
    localparam logic [1:0] OP_READ    = 2'b10;
    localparam logic [1:0] OP_WRITE   = 2'b01;
    localparam logic [1:0] TA_WRITE   = 2'b10;

    localparam logic [BIT_W-1:0] PREAMBLE_BITS    = BIT_W'(32);
    localparam logic [BIT_W-1:0] READ_RELEASE_BIT = BIT_W'(46);
    localparam logic [BIT_W-1:0] READ_CAPTURE_BIT = BIT_W'(48);
    localparam logic [BIT_W-1:0] LAST_BIT         = BIT_W'(63);

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  reg_addr;
        logic [15:0] write_data;
        logic        mdio_in;
    } t_item;

    typedef struct packed {
        logic        mdc_level;
        logic        mdio_drive;
        logic        mdio_enable;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
    } t_result;

endpackage

FILE: rtl/mdiomm_engine.sv
// Frame sequencer: configuration, MDC phase timing, frame shift and read capture
module mdiomm_engine
    import mdiomm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_item                 i_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result               o_res
);

    logic [4:0]        r_phy_address;
    logic [HALF_W-1:0] r_half_period;

    logic              r_clock_line,   n_clock_line;
    logic              r_drive_bit,    n_drive_bit;
    logic              r_drive_enable, n_drive_enable;
    logic              r_active,       n_active;
    logic              r_is_read,      n_is_read;
    logic [BIT_W-1:0]  r_bit_index,    n_bit_index;
    logic [HALF_W-1:0] r_phase_count,  n_phase_count;
    logic              r_in_high,      n_in_high;
    logic [31:0]       r_frame_shift,  n_frame_shift;
    logic [15:0]       r_capture,      n_capture;
    logic [15:0]       r_last_read,    n_last_read;
    logic              n_done;

    logic [HALF_W-1:0] phase_inc;
    logic [HALF_W-1:0] half_eff;
    logic              phase_end;
    logic [BIT_W-1:0]  bit_next;
    logic [1:0]        line_next;

    // {enable, level} for a given bit of the frame
    function automatic logic [1:0] line_for_bit(input logic [BIT_W-1:0] b,
                                                input logic rd,
                                                input logic [31:0] fs);
        logic [1:0] res;
        if (b < PREAMBLE_BITS) begin
            res = 2'b11;
        end else if (rd && b >= READ_RELEASE_BIT) begin
            res = 2'b00;
        end else begin
            res = {1'b1, fs[~b[4:0]]};
        end
        return res;
    endfunction

    assign phase_inc = r_phase_count + HALF_W'(1);
    assign half_eff  = (r_half_period == '0) ? HALF_W'(1) : r_half_period;
    assign phase_end = (phase_inc >= half_eff) || (phase_inc == '0);
    assign bit_next  = r_bit_index + BIT_W'(1);
    assign line_next = line_for_bit(bit_next, r_is_read, r_frame_shift);

    always_comb begin
        n_clock_line   = r_clock_line;
        n_drive_bit    = r_drive_bit;
        n_drive_enable = r_drive_enable;
        n_active       = r_active;
        n_is_read      = r_is_read;
        n_bit_index    = r_bit_index;
        n_phase_count  = r_phase_count;
        n_in_high      = r_in_high;
        n_frame_shift  = r_frame_shift;
        n_capture      = r_capture;
        n_last_read    = r_last_read;
        n_done         = 1'b0;
        if ((i_item.func == FUNC_READ || i_item.func == FUNC_WRITE) && !r_active) begin
            if (i_item.func == FUNC_READ) begin
                n_is_read     = 1'b1;
                n_frame_shift = {START_BITS, OP_READ, r_phy_address, i_item.reg_addr, 18'd0};
            end else begin
                n_is_read     = 1'b0;
                n_frame_shift = {START_BITS, OP_WRITE, r_phy_address, i_item.reg_addr,
                                 TA_WRITE, i_item.write_data};
            end
            n_active       = 1'b1;
            n_bit_index    = '0;
            n_phase_count  = '0;
            n_in_high      = 1'b0;
            n_capture      = '0;
            n_clock_line   = 1'b0;
            n_drive_enable = 1'b1;
            n_drive_bit    = 1'b1;
        end else if (i_item.func == FUNC_TICK && r_active) begin
            n_phase_count = phase_inc;
            if (phase_end) begin
                n_phase_count = '0;
                if (!r_in_high) begin
                    if (r_is_read && r_bit_index >= READ_CAPTURE_BIT) begin
                        n_capture = {r_capture[14:0], i_item.mdio_in};
                    end
                    n_clock_line = 1'b1;
                    n_in_high    = 1'b1;
                end else if (r_bit_index == LAST_BIT) begin
                    if (r_is_read) begin
                        n_last_read = r_capture;
                    end
                    n_active       = 1'b0;
                    n_done         = 1'b1;
                    n_drive_enable = 1'b0;
                    n_drive_bit    = 1'b0;
                    n_clock_line   = 1'b1;
                    n_in_high      = 1'b0;
                    n_bit_index    = '0;
                end else begin
                    n_bit_index    = bit_next;
                    n_clock_line   = 1'b0;
                    n_in_high      = 1'b0;
                    n_drive_enable = line_next[1];
                    n_drive_bit    = line_next[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phy_address  <= '0;
            r_half_period  <= HALF_PERIOD_RESET;
            r_clock_line   <= 1'b1;
            r_drive_bit    <= 1'b0;
            r_drive_enable <= 1'b0;
            r_active       <= 1'b0;
            r_is_read      <= 1'b0;
            r_bit_index    <= '0;
            r_phase_count  <= '0;
            r_in_high      <= 1'b0;
            r_frame_shift  <= '0;
            r_capture      <= '0;
            r_last_read    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PHY_ADDRESS) begin
                    r_phy_address <= i_cfg_data[4:0];
                end else begin
                    r_half_period <= i_cfg_data[HALF_W-1:0];
                end
            end
            if (i_step) begin
                r_clock_line   <= n_clock_line;
                r_drive_bit    <= n_drive_bit;
                r_drive_enable <= n_drive_enable;
                r_active       <= n_active;
                r_is_read      <= n_is_read;
                r_bit_index    <= n_bit_index;
                r_phase_count  <= n_phase_count;
                r_in_high      <= n_in_high;
                r_frame_shift  <= n_frame_shift;
                r_capture      <= n_capture;
                r_last_read    <= n_last_read;
            end
        end
    end

    always_comb begin
        o_res.mdc_level   = n_clock_line;
        o_res.mdio_drive  = n_drive_enable & n_drive_bit;
        o_res.mdio_enable = n_drive_enable;
        o_res.busy_res    = n_active;
        o_res.done_res    = n_done;
        o_res.read_data   = n_last_read;
    end

endmodule

FILE: rtl/mdio_management_master.sv
// Clause-22 MDIO management master: one beat in (tick or start command),
// one result beat out per input beat. Throughput is one beat per clock
// while the output does not stall; an accepted beat sits in the input
// register, is applied to the frame sequencer and lands in the output
// register, from which its result is offered; it waits while the output stalls.
// The only work per beat is one phase
// counter increment and compare plus a bit select, so nothing iterates.
// The output register decouples the two sides; the input side stalls only
// while both the input and output registers are full and the output stalls.
module mdio_management_master
    import mdiomm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_func,
    input  logic [4:0]            i_reg_addr,
    input  logic [15:0]           i_write_data,
    input  logic                  i_mdio_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_mdc_level,
    output logic                  o_mdio_drive,
    output logic                  o_mdio_enable,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [15:0]           o_read_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "mdio_management_master_assert.svh"

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result step_res;
    logic    advance;
    logic    accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    mdiomm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_item     (r_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_item <= '{func: i_func, reg_addr: i_reg_addr,
                        write_data: i_write_data, mdio_in: i_mdio_in};
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mdc_level   = r_res.mdc_level;
    assign o_mdio_drive  = r_res.mdio_drive;
    assign o_mdio_enable = r_res.mdio_enable;
    assign o_busy_res    = r_res.busy_res;
    assign o_done_res    = r_res.done_res;
    assign o_read_data   = r_res.read_data;

    `MDIOMM_ASSERT_NOW(a_done_not_busy, o_out_valid && o_done_res, !o_busy_res, "done while busy")
    `MDIOMM_ASSERT_NOW(a_idle_line, o_out_valid && !o_busy_res, o_mdc_level && !o_mdio_enable, "idle line not parked")
    `MDIOMM_ASSERT_NOW(a_released_low, o_out_valid && !o_mdio_enable, !o_mdio_drive, "released line driven high")
    `MDIOMM_ASSERT_NEXT(a_step_fills_out, advance, r_out_valid, "stepped beat lost")

endmodule

FILE: dv/tb_mdio_management_master.sv
// Testbench for the MDIO management master: random and directed frames against a predictor
`timescale 1ns / 100ps

module tb_mdio_management_master;
    import mdiomm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_GAP        = 11;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Frame predictor and the queue of result beats it expects
    class mdio_frame_scoreboard;
        logic [4:0]        phy_number;
        logic [HALF_W-1:0] half_ticks;
        logic              mdc;
        logic              drv;
        logic              drv_en;
        logic              busy;
        logic              reading;
        logic              high_phase;
        logic [BIT_W-1:0]  bit_idx;
        logic [HALF_W-1:0] phase_cnt;
        logic [31:0]       frame_word;
        logic [15:0]       capture;
        logic [15:0]       last_read;
        t_result           expected_q[$];
        int                errors;

        function new();
            phy_number = '0;
            half_ticks = HALF_PERIOD_RESET;
            mdc        = 1'b1;
            drv        = 1'b0;
            drv_en     = 1'b0;
            busy       = 1'b0;
            reading    = 1'b0;
            high_phase = 1'b0;
            bit_idx    = '0;
            phase_cnt  = '0;
            frame_word = '0;
            capture    = '0;
            last_read  = '0;
            errors     = 0;
        endfunction

        function void write_cfg(logic idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_PHY_ADDRESS) begin
                phy_number = value[4:0];
            end else begin
                half_ticks = value[HALF_W-1:0];
            end
        endfunction

        function void line_for_bit(logic [BIT_W-1:0] b);
            if (b < PREAMBLE_BITS) begin
                drv_en = 1'b1;
                drv    = 1'b1;
            end else if (reading && b >= READ_RELEASE_BIT) begin
                drv_en = 1'b0;
                drv    = 1'b0;
            end else begin
                drv_en = 1'b1;
                drv    = frame_word[5'(LAST_BIT - b)];
            end
        endfunction

        function void note_beat(t_item it);
            logic [HALF_W-1:0] hp;
            logic              done;
            t_result           r;
            done = 1'b0;
            hp   = (half_ticks == '0) ? HALF_W'(1) : half_ticks;
            if ((it.func == FUNC_READ || it.func == FUNC_WRITE) && !busy) begin
                reading = (it.func == FUNC_READ);
                if (reading) begin
                    frame_word = {START_BITS, OP_READ, phy_number, it.reg_addr, 18'd0};
                end else begin
                    frame_word = {START_BITS, OP_WRITE, phy_number, it.reg_addr, TA_WRITE,
                                  it.write_data};
                end
                busy       = 1'b1;
                bit_idx    = '0;
                phase_cnt  = '0;
                high_phase = 1'b0;
                capture    = '0;
                mdc        = 1'b0;
                line_for_bit('0);
            end else if (it.func == FUNC_TICK && busy) begin
                phase_cnt = phase_cnt + HALF_W'(1);
                if (phase_cnt >= hp || phase_cnt == '0) begin
                    phase_cnt = '0;
                    if (!high_phase) begin
                        if (reading && bit_idx >= READ_CAPTURE_BIT) begin
                            capture = {capture[14:0], it.mdio_in};
                        end
                        mdc        = 1'b1;
                        high_phase = 1'b1;
                    end else if (bit_idx >= LAST_BIT) begin
                        if (reading) begin
                            last_read = capture;
                        end
                        busy       = 1'b0;
                        done       = 1'b1;
                        drv_en     = 1'b0;
                        drv        = 1'b0;
                        mdc        = 1'b1;
                        high_phase = 1'b0;
                        bit_idx    = '0;
                    end else begin
                        bit_idx    = bit_idx + BIT_W'(1);
                        mdc        = 1'b0;
                        high_phase = 1'b0;
                        line_for_bit(bit_idx);
                    end
                end
            end
            r.mdc_level   = mdc;
            r.mdio_drive  = drv_en & drv;
            r.mdio_enable = drv_en;
            r.busy_res    = busy;
            r.done_res    = done;
            r.read_data   = last_read;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat expected none got 0x%0h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("mdc_level", 16'(want.mdc_level), 16'(got.mdc_level));
            compare_field("mdio_drive", 16'(want.mdio_drive), 16'(got.mdio_drive));
            compare_field("mdio_enable", 16'(want.mdio_enable), 16'(got.mdio_enable));
            compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
            compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
            compare_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_func;
    logic [4:0]            i_reg_addr;
    logic [15:0]           i_write_data;
    logic                  i_mdio_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_mdc_level;
    logic                  o_mdio_drive;
    logic                  o_mdio_enable;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [15:0]           o_read_data;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mdio_frame_scoreboard sb = new();
    bit                   no_gaps;

    mdio_management_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_mdio_in     (i_mdio_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mdc_level   (o_mdc_level),
        .o_mdio_drive  (o_mdio_drive),
        .o_mdio_enable (o_mdio_enable),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_data   (o_read_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_item rand_item(logic [1:0] f);
        t_item it;
        it.func       = f;
        it.reg_addr   = 5'($urandom_range(0, 31));
        it.write_data = 16'($urandom_range(0, 65535));
        it.mdio_in    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_beat(t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_func       <= it.func;
        i_reg_addr   <= it.reg_addr;
        i_write_data <= it.write_data;
        i_mdio_in    <= it.mdio_in;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_beat(it);
    endtask

    // level 0 or 1 holds MDIO in at that level, 2 or more randomises it
    task automatic send_ticks(int n, int level);
        t_item it;
        repeat (n) begin
            it = rand_item(FUNC_TICK);
            if (level < 2) begin
                it.mdio_in = 1'(level);
            end
            send_beat(it);
        end
    endtask

    // level 0 or 1 holds MDIO in at that level, 2 or more randomises it
    task automatic finish_frame(int level);
        t_item it;
        while (sb.busy) begin
            it = rand_item(FUNC_TICK);
            if (level < 2) begin
                it.mdio_in = 1'(level);
            end
            send_beat(it);
        end
    endtask

    task automatic run_frame(logic [1:0] f, logic [4:0] addr, logic [15:0] wdata, int level);
        t_item it;
        it            = rand_item(f);
        it.reg_addr   = addr;
        it.write_data = wdata;
        send_beat(it);
        finish_frame(level);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_cfg(idx, value);
    endtask

    task automatic set_config(logic [4:0] phy, logic [HALF_W-1:0] half);
        drain();
        write_reg(CFG_PHY_ADDRESS, CFG_DATA_W'(phy));
        write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(half));
    endtask

    function automatic logic [1:0] rand_command();
        return ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
    endfunction

    // mostly whole frames with random content, some ignored and out-of-turn beats
    task automatic random_run(int n);
        int    counted;
        int    roll;
        bit    paused;
        t_item it;
        counted = 0;
        paused  = 1'b0;
        while (counted < n) begin
            if (!paused && counted >= n / 2) begin
                drain();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (!sb.busy) begin
                if (roll < 80) begin
                    it = rand_item(rand_command());
                    counted++;
                end else if (roll < 90) begin
                    it = rand_item(FUNC_TICK);
                end else begin
                    it = rand_item(FUNC_UNUSED);
                end
            end else begin
                if (roll < 94) begin
                    it = rand_item(FUNC_TICK);
                    counted++;
                end else if (roll < 97) begin
                    it = rand_item(rand_command());
                end else begin
                    it = rand_item(FUNC_UNUSED);
                end
            end
            send_beat(it);
        end
        finish_frame(2);
    endtask

    initial begin : result_sink
        t_result got;
        int      gap;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            repeat (gap) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.mdc_level   = o_mdc_level;
            got.mdio_drive  = o_mdio_drive;
            got.mdio_enable = o_mdio_enable;
            got.busy_res    = o_busy_res;
            got.done_res    = o_done_res;
            got.read_data   = o_read_data;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_item       it;
        int unsigned half_choice[5];
        half_choice  = '{1, 2, 1, 0, 1};
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = FUNC_TICK;
        i_reg_addr   = '0;
        i_write_data = '0;
        i_mdio_in    = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_PHY_ADDRESS;
        i_cfg_data   = '0;
        no_gaps      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle beats, then a few bits of a frame at the default half period
        send_beat(rand_item(FUNC_TICK));
        send_beat(rand_item(FUNC_UNUSED));
        no_gaps       = 1'b1;
        it            = rand_item(FUNC_WRITE);
        it.reg_addr   = 5'd1;
        it.write_data = 16'h8001;
        send_beat(it);
        send_ticks(120, 2);
        no_gaps = 1'b0;
        set_config(5'd0, HALF_W'(1));
        finish_frame(2);

        // zero half period, top PHY address, commands while busy
        set_config(5'd31, HALF_W'(0));
        send_beat(rand_item(FUNC_TICK));
        send_beat(rand_item(FUNC_UNUSED));
        it            = rand_item(FUNC_WRITE);
        it.reg_addr   = 5'd31;
        it.write_data = 16'hffff;
        send_beat(it);
        send_beat(rand_item(FUNC_READ));
        send_beat(rand_item(FUNC_WRITE));
        send_beat(rand_item(FUNC_UNUSED));
        finish_frame(2);
        run_frame(FUNC_READ, 5'd0, 16'h0000, 1);
        run_frame(FUNC_READ, 5'd31, 16'hffff, 0);

        set_config(5'd0, HALF_W'(1));
        run_frame(FUNC_READ, 5'd21, 16'h1234, 2);
        run_frame(FUNC_WRITE, 5'd10, 16'h5a5a, 2);

        // longest half period, back to back, then a short one to end the frame
        set_config(5'($urandom_range(0, 31)), HALF_W'(1023));
        no_gaps = 1'b1;
        send_beat(rand_item(FUNC_READ));
        send_ticks(40, 2);
        no_gaps = 1'b0;
        set_config(5'($urandom_range(0, 31)), HALF_W'(1));
        finish_frame(2);

        for (int p = 0; p < 5; p++) begin
            set_config(5'($urandom_range(0, 31)), HALF_W'(half_choice[p]));
            no_gaps = (p == 3);
            random_run(40);
        end
        no_gaps = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
